@@ rtl/ipv4_header_parse_check_unit_macros.svh @@
// ----------------------------------------------------------------------------
// ipv4_header_parse_check_unit_macros.svh
// Assertion macros shared by the IPv4 header parse/check RTL.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_PARSE_CHECK_UNIT_MACROS_SVH
`define IPV4_HEADER_PARSE_CHECK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IHPC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define IHPC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ihpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ihpc_pkg
// Types and constants for the IPv4 header parse/check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ihpc_pkg;

  // Result beat kinds
  typedef enum logic [1:0] {
    KIND_OPTION  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  // Frame status codes; also used as the sticky error code (ST_OK = none)
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_BAD_VERSION  = 3'd2,
    ST_BAD_IHL      = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_BAD_CSUM     = 3'd5
  } status_e;

  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [15:0] BASE_HDR_BYTES = 16'd20;
  localparam logic [15:0] CSUM_LO_INDEX  = 16'd11;
  localparam logic [15:0] INDEX_MAX      = 16'hFFFF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Captured header information reported on a status beat
  typedef struct packed {
    status_e     status;
    logic [7:0]  protocol;
    logic [7:0]  ttl;
    logic [15:0] ident;
    logic [2:0]  flags;
    logic [12:0] frag_offset;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [5:0]  option_bytes;
  } hdr_info_t;

  // One queue entry: results caused by one input byte
  typedef struct packed {
    logic      has_data;
    kind_e     data_kind;
    logic [7:0] data_byte;
    logic      has_status;
    hdr_info_t info;
  } entry_t;

  // One output beat
  typedef struct packed {
    kind_e     kind;
    logic [7:0] out_byte;
    logic      last;
    hdr_info_t info;
  } beat_t;

endpackage

`default_nettype wire

@@ rtl/ihpc_in_if.sv @@
// ----------------------------------------------------------------------------
// ihpc_in_if
// Byte input channel: valid/ready with a frame-end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/ihpc_out_if.sv @@
// ----------------------------------------------------------------------------
// ihpc_out_if
// Result channel: option/payload bytes and the end-of-frame status.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic        last;
  logic [2:0]  status;
  logic [7:0]  protocol;
  logic [7:0]  ttl;
  logic [15:0] ident;
  logic [2:0]  flags;
  logic [12:0] frag_offset;
  logic [31:0] src_address;
  logic [31:0] dst_address;
  logic [5:0]  option_bytes;

  modport source (output valid, kind, out_byte, last, status, protocol, ttl, ident, flags,
                  frag_offset, src_address, dst_address, option_bytes, input ready);
  modport sink   (input valid, kind, out_byte, last, status, protocol, ttl, ident, flags,
                  frag_offset, src_address, dst_address, option_bytes, output ready);
endinterface

`default_nettype wire

@@ rtl/ipv4_header_parse_check_unit.sv @@
// Latency: a byte's result beat passes through the entry queue and then the registered output stage.
// Throughput: one byte per cycle while the queue is not full; a frame's final byte that also carries a
// data beat yields two output beats, absorbed by the 4-entry queue.
// Reset: rst_ni asynchronous active low; clears the parse state and queue,
// no clearing pass is needed.
// ----------------------------------------------------------------------------
// ipv4_header_parse_check_unit
// IPv4 header parser with header checksum verification: parser front,
// entry queue and result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_parse_check_unit
  import ihpc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ihpc_in_if.sink    byte_i,
  ihpc_out_if.source result_o
);

  logic   push, full, pop, empty;
  entry_t push_entry, head;

  ihpc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .full_i      (full),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  ihpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  ihpc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .result_o(result_o)
  );

endmodule

`default_nettype wire

@@ rtl/ihpc_queue.sv @@
// ----------------------------------------------------------------------------
// ihpc_queue
// Short entry queue between the parser front and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ihpc_queue
  import ihpc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  output      logic   full_o,
  input  wire logic   pop_i,
  output      entry_t head_o,
  output      logic   empty_o
);

  localparam logic [QPTR_W:0] DepthCount = (QPTR_W+1)'(QUEUE_DEPTH);

  entry_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == DepthCount);
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ihpc_front.sv @@
// ----------------------------------------------------------------------------
// ihpc_front
// Accepts frame bytes, parses the header, keeps the checksum and builds
// one queue entry per byte that causes any result.
// ----------------------------------------------------------------------------
`default_nettype none

module ihpc_front
  import ihpc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ihpc_in_if.sink     byte_i,
  input  wire logic   full_i,
  output      logic   push_o,
  output      entry_t push_entry_o
);

  logic [15:0] byte_index_q, byte_index_d;
  logic [3:0]  header_words_q, header_words_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] stored_csum_q, stored_csum_d;
  logic [15:0] decl_len_q, decl_len_d;
  status_e     error_q, error_d;
  logic [7:0]  protocol_q, protocol_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [15:0] ident_q, ident_d;
  logic [2:0]  flags_q, flags_d;
  logic [12:0] frag_q, frag_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] p;
  logic        first;
  status_e     err_start;
  logic [5:0]  hlen;
  logic        in_hdr;
  logic [16:0] add_raw;
  logic [15:0] add_fold;
  logic        csum_fail;
  logic [16:0] frame_len;
  status_e     fin_status;
  logic        has_data;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.data_byte;
  assign p            = byte_index_q;
  assign first        = (p == '0);

  // header parse, checksum and capture
  always_comb begin
    header_words_d = first ? b[3:0] : header_words_q;
    if (first) begin
      if (b[7:4] != IP_VERSION)  err_start = ST_BAD_VERSION;
      else if (b[3:0] < MIN_IHL) err_start = ST_BAD_IHL;
      else                       err_start = ST_OK;
    end else begin
      err_start = error_q;
    end
    sum_d         = first ? '0 : sum_q;
    decl_len_d    = first ? '0 : decl_len_q;
    stored_csum_d = first ? '0 : stored_csum_q;
    protocol_d    = first ? '0 : protocol_q;
    ttl_d         = first ? '0 : ttl_q;
    ident_d       = first ? '0 : ident_q;
    flags_d       = first ? '0 : flags_q;
    frag_d        = first ? '0 : frag_q;
    src_d         = first ? '0 : src_q;
    dst_d         = first ? '0 : dst_q;
    hold_d        = hold_q;

    hlen   = {header_words_d, 2'b00};
    in_hdr = (err_start == ST_OK) && (p < {10'd0, hlen});

    // ones-complement add of the word built from the held even byte
    add_raw  = {1'b0, sum_d} + {1'b0, hold_q, b};
    add_fold = add_raw[15:0] + {15'd0, add_raw[16]};

    if (in_hdr) begin
      if (!p[0]) begin
        hold_d = b;
      end else if (p != CSUM_LO_INDEX) begin
        sum_d = add_fold;
      end
      case (p)
        16'd2:   decl_len_d[15:8]    = b;
        16'd3:   decl_len_d[7:0]     = b;
        16'd4:   ident_d[15:8]       = b;
        16'd5:   ident_d[7:0]        = b;
        16'd6: begin
          flags_d       = b[7:5];
          frag_d[12:8]  = b[4:0];
        end
        16'd7:   frag_d[7:0]         = b;
        16'd8:   ttl_d               = b;
        16'd9:   protocol_d          = b;
        16'd10:  stored_csum_d[15:8] = b;
        16'd11:  stored_csum_d[7:0]  = b;
        16'd12:  src_d[31:24]        = b;
        16'd13:  src_d[23:16]        = b;
        16'd14:  src_d[15:8]         = b;
        16'd15:  src_d[7:0]          = b;
        16'd16:  dst_d[31:24]        = b;
        16'd17:  dst_d[23:16]        = b;
        16'd18:  dst_d[15:8]         = b;
        16'd19:  dst_d[7:0]          = b;
        default: ;
      endcase
    end

    // checksum verdict on the last header byte
    csum_fail = in_hdr && (p == {10'd0, hlen - 6'd1}) && (stored_csum_d != ~sum_d);
    error_d   = csum_fail ? ST_BAD_CSUM : err_start;

    byte_index_d = byte_i.frame_end ? '0 : ((p != INDEX_MAX) ? p + 1'b1 : p);
  end

  // end-of-frame status in priority order
  always_comb begin
    frame_len = {1'b0, p} + 17'd1;
    if (frame_len < {1'b0, BASE_HDR_BYTES}) begin
      fin_status = ST_SHORT;
    end else if (error_d == ST_BAD_VERSION || error_d == ST_BAD_IHL) begin
      fin_status = error_d;
    end else if (frame_len < {11'd0, hlen}) begin
      fin_status = ST_SHORT;
    end else if (frame_len != {1'b0, decl_len_d} ||
                 frame_len > 17'(MAX_FRAME_BYTES)) begin
      fin_status = ST_LEN_MISMATCH;
    end else if (error_d == ST_BAD_CSUM) begin
      fin_status = ST_BAD_CSUM;
    end else begin
      fin_status = ST_OK;
    end
  end

  // queue entry
  always_comb begin
    has_data = (err_start == ST_OK) && (!in_hdr || p >= BASE_HDR_BYTES);
    push_o   = accept && (has_data || byte_i.frame_end);

    push_entry_o.has_data          = has_data;
    push_entry_o.data_kind         = in_hdr ? KIND_OPTION : KIND_PAYLOAD;
    push_entry_o.data_byte         = b;
    push_entry_o.has_status        = byte_i.frame_end;
    push_entry_o.info.status       = fin_status;
    push_entry_o.info.protocol     = protocol_d;
    push_entry_o.info.ttl          = ttl_d;
    push_entry_o.info.ident        = ident_d;
    push_entry_o.info.flags        = flags_d;
    push_entry_o.info.frag_offset  = frag_d;
    push_entry_o.info.src_address  = src_d;
    push_entry_o.info.dst_address  = dst_d;
    push_entry_o.info.option_bytes = (header_words_d >= MIN_IHL) ?
                                     {header_words_d - MIN_IHL, 2'b00} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= '0;
      header_words_q <= '0;
      sum_q          <= '0;
      hold_q         <= '0;
      stored_csum_q  <= '0;
      decl_len_q     <= '0;
      error_q        <= ST_OK;
      protocol_q     <= '0;
      ttl_q          <= '0;
      ident_q        <= '0;
      flags_q        <= '0;
      frag_q         <= '0;
      src_q          <= '0;
      dst_q          <= '0;
    end else if (accept) begin
      byte_index_q   <= byte_index_d;
      header_words_q <= header_words_d;
      sum_q          <= sum_d;
      hold_q         <= hold_d;
      stored_csum_q  <= stored_csum_d;
      decl_len_q     <= decl_len_d;
      error_q        <= error_d;
      protocol_q     <= protocol_d;
      ttl_q          <= ttl_d;
      ident_q        <= ident_d;
      flags_q        <= flags_d;
      frag_q         <= frag_d;
      src_q          <= src_d;
      dst_q          <= dst_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ihpc_back.sv @@
// ----------------------------------------------------------------------------
// ihpc_back
// Drains queue entries into output beats: the data beat first, then the
// status beat, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_header_parse_check_unit_macros.svh"

module ihpc_back
  import ihpc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire entry_t head_i,
  input  wire logic   empty_i,
  output      logic   pop_o,
  ihpc_out_if.source  result_o
);

  logic  out_valid_q, out_valid_d;
  beat_t beat_q, beat_d;
  logic  sent_data_q, sent_data_d;
  logic  load;

  assign load = !out_valid_q || result_o.ready;

  // beat selection
  always_comb begin
    out_valid_d = out_valid_q;
    beat_d      = beat_q;
    sent_data_d = sent_data_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        if (head_i.has_data && !sent_data_q) begin
          beat_d.kind     = head_i.data_kind;
          beat_d.out_byte = head_i.data_byte;
          beat_d.last     = 1'b0;
          beat_d.info     = '0;
          sent_data_d     = head_i.has_status;
          pop_o           = !head_i.has_status;
        end else begin
          beat_d.kind     = KIND_STATUS;
          beat_d.out_byte = '0;
          beat_d.last     = 1'b1;
          beat_d.info     = head_i.info;
          sent_data_d     = 1'b0;
          pop_o           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_data_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sent_data_q <= sent_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.kind         = beat_q.kind;
  assign result_o.out_byte     = beat_q.out_byte;
  assign result_o.last         = beat_q.last;
  assign result_o.status       = beat_q.info.status;
  assign result_o.protocol     = beat_q.info.protocol;
  assign result_o.ttl          = beat_q.info.ttl;
  assign result_o.ident        = beat_q.info.ident;
  assign result_o.flags        = beat_q.info.flags;
  assign result_o.frag_offset  = beat_q.info.frag_offset;
  assign result_o.src_address  = beat_q.info.src_address;
  assign result_o.dst_address  = beat_q.info.dst_address;
  assign result_o.option_bytes = beat_q.info.option_bytes;

  // a half-delivered entry stays at the queue head
  `IHPC_ASSERT_IMP(a_half_entry_held, clk_i, rst_ni, sent_data_q, !empty_i, "half entry lost")
  // a split entry's data beat is loaded as a valid non-status beat
  `IHPC_ASSERT_NXT(a_split_then_status, clk_i, rst_ni, load && sent_data_d && !sent_data_q,
                   out_valid_q && beat_q.kind != KIND_STATUS, "split order broken")
  // status beats close the frame, data beats do not
  `IHPC_ASSERT_IMP(a_last_on_status, clk_i, rst_ni, out_valid_q,
                   beat_q.last == (beat_q.kind == KIND_STATUS), "last mismatch")

endmodule

`default_nettype wire
